// ===== hdl/encoder_period_speed_meter_assert.svh =====
// assertion macros used by the checker file of the speed meter
`ifndef ENCODER_PERIOD_SPEED_METER_ASSERT_SVH
`define ENCODER_PERIOD_SPEED_METER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define EPSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define EPSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/epsm_pkg.sv =====
// shared widths, constants and types of the encoder period speed meter
`default_nettype none

package epsm_pkg;

	localparam int STAMP_W = 16;
	localparam int NUM_W   = 32;
	localparam int WSUM_W  = 20;
	localparam int CNT_W   = $clog2(NUM_W);

	localparam logic [NUM_W-1:0] NUMERATOR_RESET = 32'd595739051;

	// status from the serial divider to the control sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// ===== hdl/encoder_period_speed_meter.sv =====
// encoder period speed meter: control sequencer, per-channel state and output register
//
// Each request on the input channel (in_valid/in_ready) is one encoder edge capture:
// channel number and a 16-bit timer stamp. The block works out the period since the
// last capture on that channel, replaces the oldest entry of the channel's ring of
// periods, updates the running window sum and divides numerator_q by that sum.
// One result request per capture leaves on out_valid/out_ready, in capture order.
// The numerator register is loaded through cfg_valid/cfg_ready/cfg_data, always ready.
// From input acceptance a capture passes the sequencer states S_READ (ring ram read),
// S_UPDATE (ring write, divider start), S_DIV (the bit-serial divider, one quotient bit
// per cycle, until its done flag) and S_OUT (output load). in_ready is high only while
// no capture is in work, so a new capture is taken only once the last one is through.
// The result sits in an output register; the next capture is accepted and processed
// while it waits, and only the load of the following result holds for out_ready.
// Reset clears stamps, sums and ring indexes and sets the numerator to its reset
// value. The ring ram is not swept: each ring slot reads as zero until the channel's
// ring index has wrapped once, so the block is usable straight after reset.
`default_nettype none

module encoder_period_speed_meter #(
	parameter int WINDOW_DEPTH = 10,
	parameter int CHANNELS     = 2
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [epsm_pkg::NUM_W-1:0]       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             channel,
	input  wire logic [epsm_pkg::STAMP_W-1:0]     capture_time,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  channel_out,
	output logic      [epsm_pkg::STAMP_W-1:0]     edge_period,
	output logic      [epsm_pkg::WSUM_W-1:0]      window_sum,
	output logic      [epsm_pkg::NUM_W-1:0]       speed_q8
);

	import epsm_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int RING_D = CHANNELS * WINDOW_DEPTH;
	localparam int ADDR_W = (RING_D > 1) ? $clog2(RING_D) : 1;
	localparam int SUM_W  = $clog2(WINDOW_DEPTH * 65535 + 1);
	localparam int EXT_W  = SUM_W + WSUM_W;
	localparam logic CH_MASK = (CHANNELS > 1);
	localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_UPDATE, S_DIV, S_OUT} state_t;

	state_t               state_q;
	logic [NUM_W-1:0]     numerator_q;
	logic [CH_W-1:0]      ch_q;
	logic                 chan_in_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic [STAMP_W-1:0]   last_stamp_q [CHANNELS];
	logic [SUM_W-1:0]     run_sum_q    [CHANNELS];
	logic [IDX_W-1:0]     ring_idx_q   [CHANNELS];
	logic                 wrapped_q    [CHANNELS];
	logic [STAMP_W-1:0]   period_q;
	logic [SUM_W-1:0]     sum_q;

	logic                 out_valid_q;
	logic                 channel_out_q;
	logic [STAMP_W-1:0]   edge_period_q;
	logic [WSUM_W-1:0]    window_sum_q;
	logic [NUM_W-1:0]     speed_q;

	logic [ADDR_W-1:0]    slot;
	logic [STAMP_W-1:0]   ram_rdata;
	logic [STAMP_W-1:0]   old_period;
	logic [STAMP_W-1:0]   period;
	logic [SUM_W-1:0]     sum_next;
	logic [EXT_W-1:0]     sum_ext;
	logic                 in_take;
	logic                 out_free;
	div_status_t          div_status;
	logic [NUM_W-1:0]     quotient;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		slot       = ADDR_W'(ch_q) * DEPTH_A + ADDR_W'(ring_idx_q[ch_q]);
		// slots not yet written since reset count as zero
		old_period = wrapped_q[ch_q] ? ram_rdata : '0;
		period     = stamp_q - last_stamp_q[ch_q];
		sum_next   = run_sum_q[ch_q] - SUM_W'(old_period) + SUM_W'(period);
		sum_ext    = EXT_W'(sum_q);
	end

	epsm_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (RING_D)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_UPDATE),
		.waddr (slot),
		.wdata (period),
		.re    (state_q == S_READ),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	epsm_div #(
		.DIVISOR_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_UPDATE),
		.dividend (numerator_q),
		.divisor  (sum_next),
		.status   (div_status),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			numerator_q <= NUMERATOR_RESET;
			out_valid_q <= 1'b0;
			ch_q        <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_stamp_q[i] <= '0;
				run_sum_q[i]    <= '0;
				ring_idx_q[i]   <= '0;
				wrapped_q[i]    <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				numerator_q <= cfg_data;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						ch_q    <= CH_W'(channel & CH_MASK);
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					last_stamp_q[ch_q] <= stamp_q;
					run_sum_q[ch_q]    <= sum_next;
					if (ring_idx_q[ch_q] == LAST_IDX) begin
						ring_idx_q[ch_q] <= '0;
						wrapped_q[ch_q]  <= 1'b1;
					end else begin
						ring_idx_q[ch_q] <= ring_idx_q[ch_q] + 1'b1;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_status.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			chan_in_q <= channel;
			stamp_q   <= capture_time;
		end
		if (state_q == S_UPDATE) begin
			period_q <= period;
			sum_q    <= sum_next;
		end
		if (state_q == S_OUT && out_free) begin
			channel_out_q <= chan_in_q;
			edge_period_q <= period_q;
			window_sum_q  <= sum_ext[WSUM_W-1:0];
			speed_q       <= quotient;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = channel_out_q;
	assign edge_period = edge_period_q;
	assign window_sum  = window_sum_q;
	assign speed_q8    = speed_q;

endmodule

`default_nettype wire

// ===== hdl/epsm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module epsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 20
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/epsm_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module epsm_div #(
	parameter int DIVISOR_W = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [epsm_pkg::NUM_W-1:0]     dividend,
	input  wire logic [DIVISOR_W-1:0]           divisor,
	output epsm_pkg::div_status_t               status,
	output logic      [epsm_pkg::NUM_W-1:0]     quotient
);

	import epsm_pkg::*;

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t              state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic                 zero_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [NUM_W-1:0]     quo_q;

	logic [DIVISOR_W:0]   shifted;
	logic [DIVISOR_W+1:0] diff;
	logic                 borrow;

	// bring down the next dividend bit and trial-subtract
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, divisor_q};
		borrow  = diff[DIVISOR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= '0;
					end
				end
				D_RUN: begin
					cnt_q  <= cnt_q + 1'b1;
					done_q <= (cnt_q == CNT_W'(NUM_W - 1));
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			divisor_q <= divisor;
			zero_q    <= (divisor == '0);
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (state_q == D_RUN) begin
			rem_q <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ~borrow};
		end
	end

	assign status.busy = (state_q == D_RUN);
	assign status.done = done_q;
	assign quotient    = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

// ===== hdl/epsm_checker.sv =====
// port-level checker of the speed meter and its bind
`default_nettype none

`include "encoder_period_speed_meter_assert.svh"

module epsm_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         channel_out,
	input wire logic [epsm_pkg::STAMP_W-1:0] edge_period,
	input wire logic [epsm_pkg::WSUM_W-1:0]  window_sum,
	input wire logic [epsm_pkg::NUM_W-1:0]   speed_q8
);

	import epsm_pkg::*;

	// stalled result keeps its payload
	`EPSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(channel_out) && $stable(edge_period) && $stable(window_sum) && $stable(speed_q8), "result changed while stalled")

	// one capture in work at a time
	`EPSM_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "input ready right after a request")

	// a new result appears as the sequencer returns to idle
	`EPSM_ASSERT_NOW(a_rise_idle, $rose(out_valid), in_ready, "result loaded while busy")

	// no result can follow an accepted capture in the next cycle
	`EPSM_ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind encoder_period_speed_meter epsm_checker u_epsm_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the encoder period speed meter
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import epsm_pkg::*;

	localparam int RING_DEPTH   = 10;
	localparam int SETTLE       = 40;
	localparam int HOLD_CYCLES  = 500;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 400;

	typedef struct packed {
		logic               ch;
		logic [STAMP_W-1:0] period;
		logic [WSUM_W-1:0]  wsum;
		logic [NUM_W-1:0]   speed;
	} speed_result_t;

	// per-channel period window and the speed it yields, plus the queue of results owed
	class speed_scoreboard;
		logic [STAMP_W-1:0] last_stamp[2];
		logic [STAMP_W-1:0] period_ring[2][RING_DEPTH];
		int unsigned        ring_pos[2];
		logic [31:0]        running_sum[2];
		logic [NUM_W-1:0]   numerator;
		speed_result_t      owed[$];
		int                 errors;

		function new();
			numerator = NUMERATOR_RESET;
			errors = 0;
			for (int c = 0; c < 2; c++) begin
				last_stamp[c] = '0;
				ring_pos[c] = 0;
				running_sum[c] = '0;
				for (int i = 0; i < RING_DEPTH; i++)
					period_ring[c][i] = '0;
			end
		endfunction

		function void set_numerator(logic [NUM_W-1:0] value);
			numerator = value;
		endfunction

		function void note_capture(logic ch, logic [STAMP_W-1:0] stamp);
			speed_result_t      r;
			logic [STAMP_W-1:0] period;
			logic [31:0]        sum;
			int unsigned        pos;
			pos = ring_pos[ch];
			period = stamp - last_stamp[ch];
			sum = running_sum[ch] - period_ring[ch][pos] + period;
			running_sum[ch] = sum;
			period_ring[ch][pos] = period;
			ring_pos[ch] = (pos + 1) % RING_DEPTH;
			last_stamp[ch] = stamp;
			r.ch = ch;
			r.period = period;
			r.wsum = sum[WSUM_W-1:0];
			r.speed = (sum == 0) ? '0 : numerator / sum;
			owed.push_back(r);
		endfunction

		function void check_result(logic ch, logic [STAMP_W-1:0] period,
				logic [WSUM_W-1:0] wsum, logic [NUM_W-1:0] speed);
			speed_result_t want;
			if (owed.size() == 0) begin
				$error("result with nothing owed: channel_out %0d edge_period %0d", ch, period);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (ch !== want.ch) begin
				$error("channel_out: expected %0d, got %0d", want.ch, ch);
				errors++;
			end
			if (period !== want.period) begin
				$error("edge_period: expected %0d, got %0d", want.period, period);
				errors++;
			end
			if (wsum !== want.wsum) begin
				$error("window_sum: expected %0d, got %0d", want.wsum, wsum);
				errors++;
			end
			if (speed !== want.speed) begin
				$error("speed_q8: expected %0d, got %0d", want.speed, speed);
				errors++;
			end
		endfunction

		function int outstanding();
			return owed.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [NUM_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               channel = 1'b0;
	logic [STAMP_W-1:0] capture_time = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               channel_out;
	logic [STAMP_W-1:0] edge_period;
	logic [WSUM_W-1:0]  window_sum;
	logic [NUM_W-1:0]   speed_q8;

	speed_scoreboard    sb;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 hold_trig = 0;
	int                 hold_seen = 0;
	int                 hold_left = 0;
	int                 cycle_count = 0;
	logic [STAMP_W-1:0] next_stamp[2];

	encoder_period_speed_meter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.capture_time (capture_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.channel_out  (channel_out),
		.edge_period  (edge_period),
		.window_sum   (window_sum),
		.speed_q8     (speed_q8)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// capture and result monitors: both sample the pre-edge values of the handshake
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_capture(channel, capture_time);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(channel_out, edge_period, window_sum, speed_q8);
	end

	// receiver: random back-pressure, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen = hold_trig;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// valid stays high after acceptance; the next call replaces the payload in the same step
	task automatic send_capture(input logic ch, input logic [STAMP_W-1:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		capture_time <= stamp;
		next_stamp[ch] = stamp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_numerator(input logic [NUM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_numerator(value);
	endtask

	task automatic run_random(input int count, input bit pressure);
		int                 n;
		int                 mode;
		int                 run_left;
		logic               run_ch;
		logic [STAMP_W-1:0] run_step;
		logic               ch;
		logic [STAMP_W-1:0] stamp;
		run_left = 0;
		run_ch = 1'b0;
		run_step = '0;
		for (n = 0; n < count; n++) begin
			if (pressure && n == count / 4)
				hold_trig++;
			if (pressure && n == count / 2)
				wait_drained();
			if (run_left > 0) begin
				// long runs fill the window with zeros or with the widest period
				run_left--;
				ch = run_ch;
				stamp = next_stamp[ch] + run_step;
			end else begin
				ch = 1'($urandom_range(1));
				mode = $urandom_range(99);
				if (mode < 3) begin
					run_left = 10;
					run_ch = ch;
					run_step = '0;
					stamp = next_stamp[ch];
				end else if (mode < 6) begin
					run_left = 10;
					run_ch = ch;
					run_step = '1;
					stamp = next_stamp[ch] + run_step;
				end else if (mode < 16) begin
					stamp = STAMP_W'($urandom_range(65535));
				end else if (mode < 26) begin
					stamp = next_stamp[ch];
				end else if (mode < 46) begin
					stamp = next_stamp[ch] + STAMP_W'($urandom_range(65535));
				end else begin
					stamp = next_stamp[ch] + STAMP_W'($urandom_range(3000, 1));
				end
			end
			send_capture(ch, stamp);
		end
		wait_drained();
	endtask

	initial begin
		sb = new();
		next_stamp[0] = '0;
		next_stamp[1] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: first capture from a zero stamp, wrap both ways, full window
		// of widest periods, then a window of zero periods giving a zero sum
		send_capture(1'b0, 16'd0);
		send_capture(1'b0, 16'hFFFF);
		send_capture(1'b0, 16'd0);
		send_capture(1'b1, 16'd40000);
		for (int i = 1; i <= 10; i++)
			send_capture(1'b1, 16'd40000 - STAMP_W'(i));
		for (int i = 0; i < 11; i++)
			send_capture(1'b0, 16'd1234);
		wait_drained();

		write_numerator('1);
		send_idle_pct = 10;
		recv_idle_pct = 64;
		run_random(PHASE_ITEMS, 1'b0);

		write_numerator(NUM_W'(1));
		send_idle_pct = 64;
		recv_idle_pct = 10;
		run_random(PHASE_ITEMS, 1'b0);

		write_numerator($urandom());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS, 1'b1);

		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/epsm_pkg.sv
hdl/epsm_ram.sv
hdl/epsm_div.sv
hdl/encoder_period_speed_meter.sv
hdl/epsm_checker.sv
tb/sv/tb_top.sv
